// ----- sv/nns_pkg.sv -----
`default_nettype none

package nns_pkg;

    localparam int MAX_DIMENSION = 128;
    localparam int FRACTION_BITS = 16;

    localparam int DIM_W       = 8;
    localparam int ACC_W       = DIM_W + FRACTION_BITS;
    localparam int ADDR_W      = $clog2(MAX_DIMENSION * MAX_DIMENSION);
    localparam int STORE_DEPTH = MAX_DIMENSION * MAX_DIMENSION;
    localparam int PIXEL_W     = 32;
    localparam int COORD_W     = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int DIV_COUNT_W = $clog2(ACC_W);

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;

    // request kinds carried on the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

    typedef struct packed {
        logic load;
        logic emit;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic target_zero;
    } status_t;

    function automatic logic [DIM_W-1:0] source_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] target_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/nns_div.sv -----
`default_nettype none

module nns_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [nns_pkg::ACC_W-1:0]   numer,
    input  wire logic [nns_pkg::DIM_W-1:0]   denom,
    output logic                             busy,
    output logic [nns_pkg::ACC_W-1:0]        quot
);
    import nns_pkg::*;

    logic                   busy_reg, busy_next;
    logic [DIV_COUNT_W-1:0] count_reg, count_next;
    logic [ACC_W-1:0]       num_reg, num_next;
    logic [ACC_W-1:0]       quot_reg, quot_next;
    logic [DIM_W-1:0]       rem_reg, rem_next;
    logic [DIM_W-1:0]       den_reg, den_next;
    logic [DIM_W:0]         trial;
    logic [DIM_W:0]         diff;
    logic                   q_bit;

    // restoring division, one quotient bit a cycle
    always_comb begin
        trial      = {rem_reg, num_reg[ACC_W-1]};
        diff       = trial - {1'b0, den_reg};
        q_bit      = (trial >= {1'b0, den_reg});
        busy_next  = busy_reg;
        count_next = count_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (start) begin
            num_next   = numer;
            den_next   = denom;
            rem_next   = '0;
            count_next = '0;
            quot_next  = '0;
            // zero divisor gives a zero step at once
            busy_next  = (denom != '0);
        end else if (busy_reg) begin
            rem_next   = q_bit ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quot_next  = {quot_reg[ACC_W-2:0], q_bit};
            num_next   = {num_reg[ACC_W-2:0], 1'b0};
            count_next = count_reg + DIV_COUNT_W'(1);
            if (count_reg == DIV_COUNT_W'(ACC_W - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            quot_reg  <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            quot_reg  <= quot_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- sv/nns_datapath.sv -----
`default_nettype none

module nns_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [nns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [nns_pkg::DIM_W-1:0]       cfg_data,
    input  wire nns_pkg::cmd_t                   cmd,
    output nns_pkg::status_t                     status,
    input  wire logic [nns_pkg::PIXEL_W-1:0]     s_pixel,
    output logic [nns_pkg::PIXEL_W-1:0]          pixel_out,
    output logic [nns_pkg::COORD_W-1:0]          target_column,
    output logic [nns_pkg::COORD_W-1:0]          target_row,
    output logic                                 row_end,
    output logic                                 frame_end
);
    import nns_pkg::*;

    logic [DIM_W-1:0] source_width_reg, source_height_reg;
    logic [DIM_W-1:0] target_width_reg, target_height_reg;
    logic [DIM_W-1:0] sw_c, sh_c, tw_c, th_c;

    logic [ADDR_W-1:0]  load_index_reg, load_index_next;
    logic [ACC_W-1:0]   col_acc_reg, col_acc_next;
    logic [ACC_W-1:0]   row_acc_reg, row_acc_next;
    logic [COORD_W-1:0] out_col_reg, out_col_next;
    logic [COORD_W-1:0] out_row_reg, out_row_next;

    logic [ACC_W-1:0] column_step, row_step;
    logic             col_busy, row_busy;

    logic [PIXEL_W-1:0] mem [STORE_DEPTH];
    logic [PIXEL_W-1:0] pixel_reg;
    logic [COORD_W-1:0] col_q_reg, row_q_reg;
    logic               row_end_reg, frame_end_reg;

    logic [DIM_W-1:0]   xd, yd;
    logic [2*DIM_W-1:0] yd_times_sw;
    logic [2*DIM_W-1:0] addr_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic [2*DIM_W-1:0] pixel_count;
    logic [ADDR_W:0]    load_count;
    logic               is_row_end, is_frame_end;

    assign sw_c = source_dim(source_width_reg);
    assign sh_c = source_dim(source_height_reg);
    assign tw_c = target_dim(target_width_reg);
    assign th_c = target_dim(target_height_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= DIM_W'(1);
            source_height_reg <= DIM_W'(1);
            target_width_reg  <= '0;
            target_height_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                CFG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                CFG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nns_div u_col_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   ({sw_c, FRACTION_BITS'(0)}),
        .denom   (tw_c),
        .busy    (col_busy),
        .quot    (column_step)
    );

    nns_div u_row_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   ({sh_c, FRACTION_BITS'(0)}),
        .denom   (th_c),
        .busy    (row_busy),
        .quot    (row_step)
    );

    assign status.div_busy    = col_busy | row_busy;
    assign status.target_zero = (tw_c == '0) || (th_c == '0);

    // source address from the integer parts of the accumulators
    always_comb begin
        xd          = col_acc_reg[ACC_W-1:FRACTION_BITS];
        yd          = row_acc_reg[ACC_W-1:FRACTION_BITS];
        yd_times_sw = {DIM_W'(0), yd} * {DIM_W'(0), sw_c};
        addr_full   = yd_times_sw + {DIM_W'(0), xd};
        rd_addr     = addr_full[ADDR_W-1:0];
    end

    always_comb begin
        pixel_count  = {DIM_W'(0), sw_c} * {DIM_W'(0), sh_c};
        load_count   = {1'b0, load_index_reg} + (ADDR_W+1)'(1);
        is_row_end   = ({1'b0, out_col_reg} + DIM_W'(1)) >= tw_c;
        is_frame_end = is_row_end && (({1'b0, out_row_reg} + DIM_W'(1)) >= th_c);

        load_index_next = load_index_reg;
        col_acc_next    = col_acc_reg;
        row_acc_next    = row_acc_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;

        if (cmd.load) begin
            if ({{(2*DIM_W-ADDR_W-1){1'b0}}, load_count} >= pixel_count)
                load_index_next = '0;
            else
                load_index_next = load_count[ADDR_W-1:0];
        end

        if (cmd.emit) begin
            if (is_row_end) begin
                out_col_next = '0;
                col_acc_next = '0;
                if (is_frame_end) begin
                    out_row_next = '0;
                    row_acc_next = '0;
                end else begin
                    out_row_next = out_row_reg + COORD_W'(1);
                    row_acc_next = row_acc_reg + row_step;
                end
            end else begin
                out_col_next = out_col_reg + COORD_W'(1);
                col_acc_next = col_acc_reg + column_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_index_reg <= '0;
            col_acc_reg    <= '0;
            row_acc_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
        end else begin
            load_index_reg <= load_index_next;
            col_acc_reg    <= col_acc_next;
            row_acc_reg    <= row_acc_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
        end
    end

    // frame store, read data held until the next emit
    always_ff @(posedge aclk) begin
        if (cmd.load) mem[load_index_reg] <= s_pixel;
        if (cmd.emit) begin
            pixel_reg     <= mem[rd_addr];
            col_q_reg     <= out_col_reg;
            row_q_reg     <= out_row_reg;
            row_end_reg   <= is_row_end;
            frame_end_reg <= is_frame_end;
        end
    end

    assign pixel_out     = pixel_reg;
    assign target_column = col_q_reg;
    assign target_row    = row_q_reg;
    assign row_end       = row_end_reg;
    assign frame_end     = frame_end_reg;

endmodule

`default_nettype wire

// ----- sv/nns_ctrl.sv -----
`default_nettype none

module nns_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             s_command,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output nns_pkg::cmd_t         cmd,
    input  wire nns_pkg::status_t status
);
    import nns_pkg::*;

    typedef enum logic [2:0] {
        S_READY  = 3'b001,
        S_START  = 3'b010,
        S_DIVIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   s_accept;

    assign s_tready = (state_reg == S_READY) && !cfg_we && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        cmd.load      = s_accept && (s_command == CMD_LOAD);
        cmd.emit      = s_accept && (s_command == CMD_EMIT) && !status.target_zero;
        cmd.div_start = (state_reg == S_START);
    end

    // every register write restarts the step division
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_READY:  if (cfg_we) state_next = S_START;
            S_START:  if (!cfg_we) state_next = S_DIVIDE;
            S_DIVIDE: begin
                if (cfg_we) state_next = S_START;
                else if (!status.div_busy) state_next = S_READY;
            end
            default:  state_next = S_READY;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_READY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ----- sv/nearest_neighbor_scaler.sv -----
// nearest-neighbour scaler with a 128 x 128 frame store
// input stream: s_tuser selects the request, low loads s_tdata as the next source
//   pixel in raster order, high emits the next target pixel
// output stream: one item per emit while both target sizes are non-zero; tdata holds
//   the pixel, its column and its row, tlast marks the end of a row and tuser the
//   end of the frame
// configuration: cfg_we with cfg_index 0..3 writes source width, source height,
//   target width and target height; each write recomputes both 8.16 steps with a
//   bit-serial divider, and the input stays not ready from the write until both
//   divisions of the last write finish
// throughput: one request per cycle unless dividing or stalled; an emit shows its
//   result in the cycle after acceptance, the frame store read being registered
// a stalled receiver holds the result register; a new request is taken in the cycle
//   the waiting result is taken
// reset: registers return to source 1 x 1 and target 0 x 0, counters and
//   accumulators clear; the frame store keeps no reset and must be loaded first
`default_nettype none

module nearest_neighbor_scaler (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [nns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [nns_pkg::DIM_W-1:0]       cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,   // pixel_in[31:0]
    input  wire logic                            s_tuser,   // command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [47:0]                          m_tdata,   // pixel_out[31:0],
                                                            // target_column[38:32],
                                                            // target_row[45:39], zero
    output logic                                 m_tlast,   // row_end
    output logic                                 m_tuser    // frame_end
);
    import nns_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [PIXEL_W-1:0] pixel_out;
    logic [COORD_W-1:0] target_column, target_row;

    nns_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    nns_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .s_pixel       (s_tdata),
        .pixel_out     (pixel_out),
        .target_column (target_column),
        .target_row    (target_row),
        .row_end       (m_tlast),
        .frame_end     (m_tuser)
    );

    assign m_tdata = {2'b00, target_row, target_column, pixel_out};

endmodule

`default_nettype wire
